### design/tped_pkg.sv
`timescale 1ns / 1ps
package tped_pkg;
    localparam int DIR_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int EDGE_BITS = 2;
    localparam int Q_STEPS = 16;
    localparam logic [FRAC_BITS-1:0] FRAC_RESET = 16'd3277;
    localparam logic [EDGE_BITS-1:0] EDGE_BA = 2'd0;
    localparam logic [EDGE_BITS-1:0] EDGE_CB = 2'd1;
    localparam logic [EDGE_BITS-1:0] EDGE_AC = 2'd2;
    localparam logic [DIR_BITS-1:0] DIR_ONE = 16'd32767;
endpackage

### design/tped_in_if.sv
`timescale 1ns / 1ps
interface tped_in_if #(parameter int COORD_BITS = 24);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

### design/tped_out_if.sv
`timescale 1ns / 1ps
interface tped_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [1:0] chosen_edge;
    logic degenerate;
    modport source (output valid, dir_x, dir_y, dir_z, chosen_edge, degenerate, input ready);
    modport sink (input valid, dir_x, dir_y, dir_z, chosen_edge, degenerate, output ready);
endinterface

### design/triangle_panel_edge_direction_core.sv
`timescale 1ns / 1ps
// triangle edge direction pipeline
// in: one triangle word (three vertices) on a valid/ready channel
// out: one direction word per triangle: q1.15 unit vector of the shortest
//   edge that is not below min_edge_fraction of the longest edge, its index
//   and a degenerate flag when every edge has zero length
// cfg_we/cfg_data write min_edge_fraction; write only while the pipe is empty
// 23 register stages; out.valid is the last bit of a valid shift register;
// one triangle per cycle is sustained while the receiver does not stall; the
// 16-stage square-root-free search rounds each component, one bit per stage
// the pipe advances as a whole; when the receiver stalls the last stage holds
// and in.ready drops only once that stage is full and held, so nothing is
// lost or repeated
// reset empties every stage and sets min_edge_fraction to 3277
module triangle_panel_edge_direction_core #(
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [tped_pkg::FRAC_BITS-1:0] cfg_data,
    tped_in_if.sink in,
    tped_out_if.source out
);
    import tped_pkg::*;

    localparam int EW = COORD_BITS + 1;     // edge component width
    localparam int MW = COORD_BITS;         // magnitude width
    localparam int SW = 2 * MW;             // squared component
    localparam int LW = 2 * MW + 2;         // squared length
    localparam int FW = LW + 32;            // scaled length
    localparam int AW = LW + 32;            // length times q^2
    localparam int BW = LW + 16;            // length times q
    localparam int XW = LW + 34;            // length times (2q-1)^2
    localparam int NS = 7 + Q_STEPS;

    logic adv;
    logic [NS-1:0] v_reg;
    logic [FRAC_BITS-1:0] frac_reg;

    assign adv = !v_reg[NS-1] || out.ready;
    assign in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= FRAC_RESET;
        end
        else if (cfg_we)
        begin
            frac_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in.valid};
        end
    end

    // stage 1: edges
    logic signed [EW-1:0] e1_reg [3][3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg[0][0] <= EW'(in.b_x) - EW'(in.a_x);
            e1_reg[0][1] <= EW'(in.b_y) - EW'(in.a_y);
            e1_reg[0][2] <= EW'(in.b_z) - EW'(in.a_z);
            e1_reg[1][0] <= EW'(in.c_x) - EW'(in.b_x);
            e1_reg[1][1] <= EW'(in.c_y) - EW'(in.b_y);
            e1_reg[1][2] <= EW'(in.c_z) - EW'(in.b_z);
            e1_reg[2][0] <= EW'(in.a_x) - EW'(in.c_x);
            e1_reg[2][1] <= EW'(in.a_y) - EW'(in.c_y);
            e1_reg[2][2] <= EW'(in.a_z) - EW'(in.c_z);
        end
    end

    // stage 2: magnitudes and signs
    logic [MW-1:0] m2_reg [3][3];
    logic s2_reg [3][3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s2_reg[k][i] <= e1_reg[k][i][EW-1];
                    m2_reg[k][i] <= e1_reg[k][i][EW-1] ? MW'(-e1_reg[k][i])
                                                       : MW'(e1_reg[k][i]);
                end
            end
        end
    end

    // stage 3: squares
    logic [MW-1:0] m3_reg [3][3];
    logic s3_reg [3][3];
    logic [SW-1:0] sq3_reg [3][3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_reg <= m2_reg;
            s3_reg <= s2_reg;
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq3_reg[k][i] <= m2_reg[k][i] * m2_reg[k][i];
                end
            end
        end
    end

    // stage 4: lengths and longest
    logic [MW-1:0] m4_reg [3][3];
    logic s4_reg [3][3];
    logic [SW-1:0] sq4_reg [3][3];
    logic [LW-1:0] l4_reg [3];
    logic [LW-1:0] len_c [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            len_c[k] = LW'(sq3_reg[k][0]) + LW'(sq3_reg[k][1]) + LW'(sq3_reg[k][2]);
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m4_reg <= m3_reg;
            s4_reg <= s3_reg;
            sq4_reg <= sq3_reg;
            l4_reg <= len_c;
        end
    end

    logic [LW-1:0] lmax_c;
    always_comb
    begin
        lmax_c = l4_reg[0];
        if (l4_reg[1] > lmax_c)
        begin
            lmax_c = l4_reg[1];
        end
        if (l4_reg[2] > lmax_c)
        begin
            lmax_c = l4_reg[2];
        end
    end

    // stage 5: longest times f, then stage 6 times f again
    logic [MW-1:0] m5_reg [3][3];
    logic s5_reg [3][3];
    logic [SW-1:0] sq5_reg [3][3];
    logic [LW-1:0] l5_reg [3];
    logic [LW+FRAC_BITS-1:0] f5_reg;
    logic z5_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m5_reg <= m4_reg;
            s5_reg <= s4_reg;
            sq5_reg <= sq4_reg;
            l5_reg <= l4_reg;
            f5_reg <= (LW+FRAC_BITS)'(lmax_c) * (LW+FRAC_BITS)'(frac_reg);
            z5_reg <= (lmax_c == '0);
        end
    end

    logic [MW-1:0] m6_reg [3][3];
    logic s6_reg [3][3];
    logic [SW-1:0] sq6_reg [3][3];
    logic [LW-1:0] l6_reg [3];
    logic [FW-1:0] f6_reg;
    logic z6_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m6_reg <= m5_reg;
            s6_reg <= s5_reg;
            sq6_reg <= sq5_reg;
            l6_reg <= l5_reg;
            f6_reg <= FW'(f5_reg) * FW'(frac_reg);
            z6_reg <= z5_reg;
        end
    end

    // stage 7: edge choice and pivot sign
    logic [1:0] best_c;
    logic use_c [3];
    logic flip_c;
    logic [MW-1:0] bm_c [3];
    always_comb
    begin
        best_c = EDGE_BA;
        for (int k = 0; k < 3; k++)
        begin
            use_c[k] = !({l6_reg[k], 32'd0} < f6_reg);
        end
        if (use_c[0])
        begin
            best_c = EDGE_BA;
            if (use_c[1] && l6_reg[1] < l6_reg[0])
            begin
                best_c = EDGE_CB;
            end
        end
        else
        begin
            best_c = use_c[1] ? EDGE_CB : EDGE_AC;
        end
        if (use_c[2] && (!use_c[0] && !use_c[1] || l6_reg[2] < l6_reg[best_c]))
        begin
            best_c = EDGE_AC;
        end
        for (int i = 0; i < 3; i++)
        begin
            bm_c[i] = m6_reg[best_c][i];
        end
        if (bm_c[0] >= bm_c[1] && bm_c[0] >= bm_c[2])
        begin
            flip_c = s6_reg[best_c][0];
        end
        else if (bm_c[1] >= bm_c[2])
        begin
            flip_c = s6_reg[best_c][1];
        end
        else
        begin
            flip_c = s6_reg[best_c][2];
        end
    end

    // search pipeline: q built msb first over 16 stages (q in 0..32768)
    // running l*q and l*q^2 give l*(2c-1)^2 for a trial c with shifts and adds
    logic [LW-1:0] pl_reg [Q_STEPS+1];
    logic [FW-1:0] pr_reg [Q_STEPS+1][3];
    logic pn_reg [Q_STEPS+1][3];
    logic [Q_STEPS-1:0] pq_reg [Q_STEPS+1][3];
    logic [AW-1:0] pa_reg [Q_STEPS+1][3];
    logic [BW-1:0] pb_reg [Q_STEPS+1][3];
    logic [1:0] pe_reg [Q_STEPS+1];
    logic pz_reg [Q_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pl_reg[0] <= l6_reg[best_c];
            pe_reg[0] <= best_c;
            pz_reg[0] <= z6_reg;
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[0][i] <= {FW'(sq6_reg[best_c][i])} << 32;
                pn_reg[0][i] <= s6_reg[best_c][i] != flip_c;
                pq_reg[0][i] <= '0;
                pa_reg[0][i] <= '0;
                pb_reg[0][i] <= '0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < Q_STEPS; g++)
        begin : g_step
            localparam int B = Q_STEPS - 1 - g;  // bit tried: 15 down to 0
            logic [Q_STEPS-1:0] cand [3];
            logic [BW-1:0] lc [3];
            logic [AW-1:0] lc2 [3];
            logic [XW-1:0] lhs [3];
            logic [Q_STEPS-1:0] nq [3];
            logic [AW-1:0] na [3];
            logic [BW-1:0] nb [3];
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cand[i] = pq_reg[g][i] | (Q_STEPS'(1) << B);
                    lc[i] = pb_reg[g][i] + (BW'(pl_reg[g]) << B);
                    lc2[i] = pa_reg[g][i] + (AW'(pb_reg[g][i]) << (B + 1))
                             + (AW'(pl_reg[g]) << (2 * B));
                    lhs[i] = (XW'(lc2[i]) << 2) - (XW'(lc[i]) << 2) + XW'(pl_reg[g]);
                    nq[i] = pq_reg[g][i];
                    na[i] = pa_reg[g][i];
                    nb[i] = pb_reg[g][i];
                    if (!(cand[i] > Q_STEPS'(32768)) && !(XW'(pr_reg[g][i]) < lhs[i]))
                    begin
                        nq[i] = cand[i];
                        na[i] = lc2[i];
                        nb[i] = lc[i];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pl_reg[g+1] <= pl_reg[g];
                    pe_reg[g+1] <= pe_reg[g];
                    pz_reg[g+1] <= pz_reg[g];
                    pr_reg[g+1] <= pr_reg[g];
                    pn_reg[g+1] <= pn_reg[g];
                    pq_reg[g+1] <= nq;
                    pa_reg[g+1] <= na;
                    pb_reg[g+1] <= nb;
                end
            end
        end
    endgenerate

    // q of 32768 saturates to 32767
    logic [DIR_BITS-1:0] d_c [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_c[i] = pq_reg[Q_STEPS][i][DIR_BITS-1] ? DIR_ONE
                                                    : pq_reg[Q_STEPS][i][DIR_BITS-1:0];
            if (pn_reg[Q_STEPS][i])
            begin
                d_c[i] = -d_c[i];
            end
        end
    end

    assign out.valid = v_reg[NS-1];
    assign out.dir_x = pz_reg[Q_STEPS] ? DIR_ONE : d_c[0];
    assign out.dir_y = pz_reg[Q_STEPS] ? '0 : d_c[1];
    assign out.dir_z = pz_reg[Q_STEPS] ? '0 : d_c[2];
    assign out.chosen_edge = pz_reg[Q_STEPS] ? EDGE_BA : pe_reg[Q_STEPS];
    assign out.degenerate = pz_reg[Q_STEPS];
endmodule
